### rtl/i2cw_pkg.sv
// Shared types and constants for the I2C register write master.
package i2cw_pkg;

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_WRITE_REG   = 2'd1,
    ACT_SET_CHANNEL = 2'd2,
    ACT_UNUSED      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE_REG,
    CMD_SET_CHANNEL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_CHANNEL_BASE   = 2'd1,
    CFG_STRETCH_TMO    = 2'd2
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned TMO_W      = 12;

  localparam logic [6:0]       DEV_ADDR_RST = 7'd64;
  localparam logic [7:0]       CH_BASE_RST  = 8'd6;
  localparam logic [TMO_W-1:0] TMO_RST      = 12'd1000;

  localparam int unsigned WRITE_REG_BYTES   = 3;
  localparam int unsigned SET_CHANNEL_BYTES = 6;

  // One classified tick as it waits in the queue between front and back.
  typedef struct packed {
    cmd_kind_t       kind;
    logic [7:0]      reg_byte;
    logic [3:0][7:0] data;
    logic            scl;
    logic            sda;
  } tick_t;

endpackage

### rtl/i2cw_if.sv
// Valid/ready channel interfaces for tick beats and result beats.
interface i2cw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  reg_index;
  logic [7:0]  reg_value;
  logic [3:0]  channel;
  logic [15:0] on_count;
  logic [15:0] off_count;
  logic        scl_sense;
  logic        sda_sense;

  modport source (output valid, action, reg_index, reg_value, channel, on_count, off_count,
                  scl_sense, sda_sense, input ready);
  modport sink (input valid, action, reg_index, reg_value, channel, on_count, off_count,
                scl_sense, sda_sense, output ready);
endinterface

interface i2cw_out_if;
  logic valid;
  logic ready;
  logic scl_release;
  logic sda_release;
  logic busy_res;
  logic done_res;
  logic nack_seen;
  logic cmd_rejected;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, nack_seen,
                  cmd_rejected, input ready);
  modport sink (input valid, scl_release, sda_release, busy_res, done_res, nack_seen,
                cmd_rejected, output ready);
endinterface

### rtl/i2cw_front.sv
// Front end: classifies each incoming tick beat and queues it for the sequencer.
module i2cw_front
  import i2cw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] channel_base,
  i2cw_in_if.sink    in_bus,
  output logic       q_valid,
  input  logic       q_ready,
  output tick_t      q_tick
);

  tick_t       dec;
  tick_t       mem_r [2];
  logic [1:0]  count_r;
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic        push;
  logic        pop;

  always_comb begin
    dec          = '0;
    dec.scl      = in_bus.scl_sense;
    dec.sda      = in_bus.sda_sense;
    dec.kind     = CMD_TICK;
    unique case (action_t'(in_bus.action))
      ACT_WRITE_REG: begin
        dec.kind     = CMD_WRITE_REG;
        dec.reg_byte = in_bus.reg_index;
        dec.data[0]  = in_bus.reg_value;
      end
      ACT_SET_CHANNEL: begin
        dec.kind     = CMD_SET_CHANNEL;
        dec.reg_byte = channel_base + {2'b00, in_bus.channel, 2'b00};
        dec.data[0]  = in_bus.on_count[7:0];
        dec.data[1]  = in_bus.on_count[15:8];
        dec.data[2]  = in_bus.off_count[7:0];
        dec.data[3]  = in_bus.off_count[15:8];
      end
      default: dec.kind = CMD_TICK;
    endcase
  end

  assign in_bus.ready = (count_r != 2'd2);
  assign push         = in_bus.valid && in_bus.ready;
  assign q_valid      = (count_r != 2'd0);
  assign pop          = q_valid && q_ready;
  assign q_tick       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/i2cw_back.sv
// Back end: bit-phase sequencer for start, bytes, acknowledge slots and stop.
module i2cw_back
  import i2cw_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [6:0]       device_address,
  input  logic [TMO_W-1:0] stretch_timeout,
  input  logic             q_valid,
  output logic             q_ready,
  input  tick_t            q_tick,
  i2cw_out_if.source       out_bus
);

  localparam int unsigned PW   = $clog2(MAX_BYTES + 1);
  localparam int unsigned IDXW = $clog2(MAX_BYTES);
  localparam int unsigned SET_CNT =
    (MAX_BYTES < SET_CHANNEL_BYTES) ? MAX_BYTES : SET_CHANNEL_BYTES;

  typedef enum logic [3:0] {
    PH_IDLE, PH_S_SCL_HI, PH_S_SDA_LO, PH_S_SCL_LO,
    PH_B_SDA, PH_B_SCL_HI, PH_B_SCL_LO,
    PH_A_SDA_HI, PH_A_SCL_HI, PH_A_SCL_LO,
    PH_P_SDA_LO, PH_P_SCL_LO, PH_P_SCL_HI, PH_P_SDA_HI
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       buf_r [MAX_BYTES];
  logic [PW-1:0]    byte_cnt_r, byte_cnt_nxt;
  logic [PW-1:0]    byte_ptr_r, byte_ptr_nxt;
  logic [2:0]       bit_ptr_r, bit_ptr_nxt;
  logic [TMO_W-1:0] stretch_r, stretch_nxt;
  logic             nack_r, nack_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             done_r, done_nxt;
  logic             rej_r, rej_nxt;
  logic             busy_r;
  logic             pop;
  logic             load;
  logic             scl_go;
  logic [7:0]       cur_byte;

  assign q_ready  = !out_valid_r || out_bus.ready;
  assign pop      = q_valid && q_ready;
  assign cur_byte = buf_r[byte_ptr_r[IDXW-1:0]];
  assign scl_go   = q_tick.scl || (stretch_r >= stretch_timeout);

  always_comb begin
    phase_nxt     = phase_r;
    byte_cnt_nxt  = byte_cnt_r;
    byte_ptr_nxt  = byte_ptr_r;
    bit_ptr_nxt   = bit_ptr_r;
    stretch_nxt   = stretch_r;
    nack_nxt      = nack_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    done_nxt      = 1'b0;
    rej_nxt       = 1'b0;
    load          = 1'b0;
    out_valid_nxt = out_bus.ready ? 1'b0 : out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (phase_r != PH_IDLE && q_tick.kind != CMD_TICK) rej_nxt = 1'b1;
      unique case (phase_r)
        PH_IDLE: begin
          if (q_tick.kind != CMD_TICK) begin
            load         = 1'b1;
            byte_cnt_nxt = (q_tick.kind == CMD_WRITE_REG) ? PW'(WRITE_REG_BYTES)
                                                          : PW'(SET_CNT);
            nack_nxt     = 1'b0;
            byte_ptr_nxt = '0;
            bit_ptr_nxt  = '0;
            stretch_nxt  = '0;
            sda_nxt      = 1'b1;
            phase_nxt    = PH_S_SCL_HI;
          end
        end
        PH_S_SCL_HI, PH_B_SCL_HI, PH_A_SCL_HI, PH_P_SCL_HI: begin
          scl_nxt = 1'b1;
          if (!scl_go) begin
            stretch_nxt = stretch_r + TMO_W'(1);
          end else begin
            stretch_nxt = '0;
            unique case (phase_r)
              PH_S_SCL_HI: phase_nxt = PH_S_SDA_LO;
              PH_B_SCL_HI: phase_nxt = PH_B_SCL_LO;
              PH_A_SCL_HI: begin
                if (q_tick.sda) nack_nxt = 1'b1;
                phase_nxt = PH_A_SCL_LO;
              end
              default:     phase_nxt = PH_P_SDA_HI;
            endcase
          end
        end
        PH_S_SDA_LO: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_S_SCL_LO;
        end
        PH_S_SCL_LO: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_B_SDA;
        end
        PH_B_SDA: begin
          sda_nxt   = cur_byte[3'd7 - bit_ptr_r];
          phase_nxt = PH_B_SCL_HI;
        end
        PH_B_SCL_LO: begin
          scl_nxt     = 1'b0;
          bit_ptr_nxt = bit_ptr_r + 3'd1;
          phase_nxt   = (bit_ptr_r == 3'd7) ? PH_A_SDA_HI : PH_B_SDA;
        end
        PH_A_SDA_HI: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_A_SCL_HI;
        end
        PH_A_SCL_LO: begin
          scl_nxt      = 1'b0;
          byte_ptr_nxt = byte_ptr_r + PW'(1);
          phase_nxt    = (byte_ptr_nxt >= byte_cnt_r) ? PH_P_SDA_LO : PH_B_SDA;
        end
        PH_P_SDA_LO: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_P_SCL_LO;
        end
        PH_P_SCL_LO: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_P_SCL_HI;
        end
        PH_P_SDA_HI: begin
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b1;
          done_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
        if (i == 0) begin
          buf_r[i] <= {device_address, 1'b0};
        end else if (i == 1) begin
          buf_r[i] <= q_tick.reg_byte;
        end else if (i < SET_CHANNEL_BYTES) begin
          if (q_tick.kind == CMD_SET_CHANNEL || i == WRITE_REG_BYTES - 1) begin
            buf_r[i] <= q_tick.data[i-2];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      byte_cnt_r  <= '0;
      byte_ptr_r  <= '0;
      bit_ptr_r   <= '0;
      stretch_r   <= '0;
      nack_r      <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      rej_r       <= 1'b0;
      busy_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      byte_ptr_r  <= byte_ptr_nxt;
      bit_ptr_r   <= bit_ptr_nxt;
      stretch_r   <= stretch_nxt;
      nack_r      <= nack_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        done_r <= done_nxt;
        rej_r  <= rej_nxt;
        busy_r <= (phase_nxt != PH_IDLE);
      end
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.scl_release  = scl_r;
  assign out_bus.sda_release  = sda_r;
  assign out_bus.busy_res     = busy_r;
  assign out_bus.done_res     = done_r;
  assign out_bus.nack_seen    = nack_r;
  assign out_bus.cmd_rejected = rej_r;

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_ptr_r <= byte_cnt_r)
    else $error("byte pointer ran past the loaded byte count");

  a_idle_no_stretch: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> stretch_r == '0)
    else $error("stretch counter left running in idle");

  a_stop_releases: assert property (@(posedge clk) disable iff (!rst_n)
    pop && phase_r == PH_P_SDA_HI |=> phase_r == PH_IDLE && scl_r && sda_r && done_r)
    else $error("stop condition did not release both lines");

  a_busy_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r == (phase_r != PH_IDLE))
    else $error("busy flag disagrees with sequencer phase");

endmodule

### rtl/i2c_register_write_master_unit.sv
// Top level of the I2C register write master: configuration registers and channel wiring.
//
// Every beat on in_bus is one bit-phase tick of the bus. It carries an optional command
// (write one register, or set one channel's on and off counts) and the SCL and SDA levels
// sensed during that tick. Every accepted beat yields exactly one beat on out_bus with the
// line drive levels, busy, done, NACK and command-rejected flags after that tick.
// Throughput is one beat per clock cycle while out_bus is not stalled; an accepted input beat
// reaches its result beat through the two-entry classification queue and the output
// register of the sequencer. A command that arrives while a transfer is running is
// dropped and flagged. When the receiver stalls out_bus, the result register holds and the
// queue takes up to two further beats before in_bus.ready falls. Reset empties the queue,
// returns the sequencer to idle with both lines released and loads the default target
// address, base register and clock-stretch timeout. The cfg port writes one register
// per cycle with cfg_we high; user must use it only while idle (block does not enforce).
module i2c_register_write_master_unit
  import i2cw_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  i2cw_in_if.sink               in_bus,
  i2cw_out_if.source            out_bus
);

  logic [6:0]       dev_addr_r;
  logic [7:0]       ch_base_r;
  logic [TMO_W-1:0] tmo_r;
  logic             q_valid;
  logic             q_ready;
  tick_t            q_tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      ch_base_r  <= CH_BASE_RST;
      tmo_r      <= TMO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DEVICE_ADDRESS: dev_addr_r <= cfg_wdata[6:0];
        CFG_CHANNEL_BASE:   ch_base_r  <= cfg_wdata[7:0];
        CFG_STRETCH_TMO:    tmo_r      <= cfg_wdata[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  i2cw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .channel_base (ch_base_r),
    .in_bus       (in_bus),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_tick       (q_tick)
  );

  i2cw_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .device_address  (dev_addr_r),
    .stretch_timeout (tmo_r),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_tick          (q_tick),
    .out_bus         (out_bus)
  );

endmodule
